@@ rtl/sbms_pkg.sv @@
package sbms_pkg;

	localparam int NUM_STACKS = 8;
	localparam int CAPACITY   = 64;

	// Slot index covers the store; slot code also needs the null value CAPACITY
	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SLOT_W = $clog2(CAPACITY + 1);
	localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

	// Fixed field widths
	localparam int NUM_W  = 4;
	localparam int WORD_W = 32;

	localparam logic [SLOT_W-1:0] NIL_SLOT = SLOT_W'(CAPACITY);

	// Operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} sbms_state_t;

	// Requests from the controller to the shared stores
	typedef struct packed {
		logic              rd_en;
		logic [IDX_W-1:0]  rd_idx;
		logic              wr_data_en;
		logic              wr_link_en;
		logic [IDX_W-1:0]  wr_idx;
		logic [WORD_W-1:0] wr_data;
		logic [SLOT_W-1:0] wr_link;
	} sbms_mem_req_t;

	// Read results from the shared stores
	typedef struct packed {
		logic [SLOT_W-1:0] link;
		logic [WORD_W-1:0] data;
	} sbms_mem_rsp_t;

endpackage

@@ rtl/sbms_store.sv @@
module sbms_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sbms_pkg::sbms_mem_req_t req,
	output sbms_pkg::sbms_mem_rsp_t rsp
);

	logic [sbms_pkg::WORD_W-1:0] data_mem [sbms_pkg::CAPACITY];
	logic [sbms_pkg::SLOT_W-1:0] link_mem [sbms_pkg::CAPACITY];
	logic [sbms_pkg::CAPACITY-1:0] link_vld_q;

	logic [sbms_pkg::WORD_W-1:0] data_rd_q;
	logic [sbms_pkg::SLOT_W-1:0] link_rd_q;
	logic                        link_vld_rd_q;
	logic [sbms_pkg::IDX_W-1:0]  rd_idx_q;

	// Write and read the data store
	always_ff @(posedge clk) begin
		if (req.wr_data_en) begin
			data_mem[req.wr_idx] <= req.wr_data;
		end
		if (req.rd_en) begin
			data_rd_q <= data_mem[req.rd_idx];
		end
	end

	// Write and read the link store
	always_ff @(posedge clk) begin
		if (req.wr_link_en) begin
			link_mem[req.wr_idx] <= req.wr_link;
		end
		if (req.rd_en) begin
			link_rd_q <= link_mem[req.rd_idx];
			rd_idx_q  <= req.rd_idx;
		end
	end

	// Track which links have been written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q    <= '0;
			link_vld_rd_q <= 1'b0;
		end else begin
			if (req.wr_link_en) begin
				link_vld_q[req.wr_idx] <= 1'b1;
			end
			if (req.rd_en) begin
				link_vld_rd_q <= link_vld_q[req.rd_idx];
			end
		end
	end

	// Unwritten link reads as the next slot; the last slot yields null
	always_comb begin
		rsp.data = data_rd_q;
		if (link_vld_rd_q) begin
			rsp.link = link_rd_q;
		end else begin
			rsp.link = sbms_pkg::SLOT_W'(rd_idx_q) + sbms_pkg::SLOT_W'(1);
		end
	end

endmodule

@@ rtl/sbms_ctrl.sv @@
module sbms_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_op,
	input  logic [sbms_pkg::NUM_W-1:0]  in_num,
	input  logic [sbms_pkg::WORD_W-1:0] in_value,
	input  logic                        out_free,
	output logic                        res_valid,
	output logic                        res_accepted,
	output logic [sbms_pkg::WORD_W-1:0] res_value,
	output sbms_pkg::sbms_mem_req_t     req,
	input  sbms_pkg::sbms_mem_rsp_t     rsp
);

	sbms_pkg::sbms_state_t state_q, state_d;

	logic                        op_q;
	logic [sbms_pkg::STK_W-1:0]  sel_q;
	logic                        in_range_q;
	logic [sbms_pkg::WORD_W-1:0] value_q;
	logic [sbms_pkg::SLOT_W-1:0] slot_q;
	logic [sbms_pkg::SLOT_W-1:0] free_head_q;
	logic [sbms_pkg::SLOT_W-1:0] heads_q [sbms_pkg::NUM_STACKS];

	logic [7:0]                  num_ext;
	logic                        in_range_c;
	logic [sbms_pkg::STK_W-1:0]  sel_c;
	logic [sbms_pkg::SLOT_W-1:0] slot_c;
	logic                        accept;
	logic                        commit;
	logic                        ok;

	// Decode the addressed stack and the slot to read
	always_comb begin
		num_ext    = 8'(in_num);
		in_range_c = (num_ext >= 8'd1) && (num_ext <= 8'(sbms_pkg::NUM_STACKS));
		sel_c      = sbms_pkg::STK_W'(num_ext - 8'd1);
		if (!in_range_c) begin
			slot_c = sbms_pkg::NIL_SLOT;
		end else if (in_op == sbms_pkg::OP_POP) begin
			slot_c = heads_q[sel_c];
		end else begin
			slot_c = free_head_q;
		end
	end

	assign ok = in_range_q && (slot_q < sbms_pkg::NIL_SLOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbms_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory requests and result
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		accept       = 1'b0;
		commit       = 1'b0;
		res_valid    = 1'b0;
		res_accepted = ok;
		res_value    = '0;
		req          = '0;
		req.rd_idx   = slot_c[sbms_pkg::IDX_W-1:0];
		req.wr_idx   = slot_q[sbms_pkg::IDX_W-1:0];
		req.wr_data  = value_q;
		req.wr_link  = (op_q == sbms_pkg::OP_POP) ? free_head_q : heads_q[sel_q];
		if (op_q == sbms_pkg::OP_POP) begin
			res_value = ok ? rsp.data : '1;
		end
		case (state_q)
			sbms_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				accept     = in_valid;
				req.rd_en  = in_valid;
				if (in_valid) begin
					state_d = sbms_pkg::ST_EXEC;
				end
			end
			sbms_pkg::ST_EXEC: begin
				if (out_free) begin
					commit         = 1'b1;
					res_valid      = 1'b1;
					req.wr_link_en = ok;
					req.wr_data_en = ok && (op_q == sbms_pkg::OP_PUSH);
					state_d        = sbms_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sbms_pkg::ST_IDLE;
			end
		endcase
	end

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= in_op;
			sel_q      <= sel_c;
			in_range_q <= in_range_c;
			value_q    <= in_value;
			slot_q     <= slot_c;
		end
	end

	// Update heads and the free list on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			for (int i = 0; i < sbms_pkg::NUM_STACKS; i++) begin
				heads_q[i] <= sbms_pkg::NIL_SLOT;
			end
		end else if (commit && ok) begin
			if (op_q == sbms_pkg::OP_PUSH) begin
				free_head_q    <= rsp.link;
				heads_q[sel_q] <= slot_q;
			end else begin
				free_head_q    <= slot_q;
				heads_q[sel_q] <= rsp.link;
			end
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == sbms_pkg::ST_EXEC)
		else $error("accepted transaction did not enter execute");

	a_no_commit_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("result issued while output register busy");

	a_free_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= sbms_pkg::NIL_SLOT)
		else $error("free head out of range");

	a_push_head: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && ok && op_q == sbms_pkg::OP_PUSH) |=> heads_q[sel_q] == $past(slot_q))
		else $error("push did not install new head");

endmodule

@@ rtl/shared_buffer_multi_stack_unit.sv @@
// Several LIFO stacks sharing one 64-entry data store with a free list.
// Input channel s_*: tuser carries the operation (bit 0: 0 push, 1 pop)
// and the stack number 1..8 (bits 4:1); tdata carries the value to push.
// Output channel m_*: tuser bit 0 is the accepted flag, tdata the popped
// value (-1 on a failed pop, 0 for any push).
// Every transaction yields exactly one result. A push fails when the store
// is full, a pop when the stack is empty; a stack number out of range fails.
// The result is computed in the execute state and then loaded into the output
// register, from which the receiver takes it.
// Each transaction reads the link and data memories and then writes them back;
// s_tready stays low until the write-back, so a new transaction waits for it.
// The output register lets a new transaction be accepted while a result
// waits; a stalled receiver holds the next result in execute, which holds
// s_tready low. Reset empties all stacks and links every slot into the free
// list; no clearing pass is needed, the block is ready right after reset.
module shared_buffer_multi_stack_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic [4:0]  s_tuser,   // operation[0], stack_number[4:1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // popped_value[31:0]
	output logic [0:0]  m_tuser    // accepted[0]
);

	sbms_pkg::sbms_mem_req_t req;
	sbms_pkg::sbms_mem_rsp_t rsp;

	logic                        out_free;
	logic                        res_valid;
	logic                        res_accepted;
	logic [sbms_pkg::WORD_W-1:0] res_value;

	logic                        m_valid_q;
	logic                        m_acc_q;
	logic [sbms_pkg::WORD_W-1:0] m_data_q;

	assign out_free = !m_valid_q || m_tready;

	sbms_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (s_tuser[0]),
		.in_num       (s_tuser[4:1]),
		.in_value     (s_tdata),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res_accepted (res_accepted),
		.res_value    (res_value),
		.req          (req),
		.rsp          (rsp)
	);

	sbms_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_acc_q  <= res_accepted;
			m_data_q <= res_value;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_acc_q;

endmodule

@@ dv/tb_shared_buffer_multi_stack_unit.sv @@
`timescale 1ns / 1ps

// Prediction of the shared-store stacks, plus the queue of outcomes still due from the block
class stack_outcome_book;
	typedef struct {
		logic        accepted;
		logic [31:0] word;
	} outcome_t;

	localparam logic [31:0] EMPTY_POP_WORD = 32'hFFFF_FFFF;

	logic [sbms_pkg::SLOT_W-1:0] link_slots [sbms_pkg::CAPACITY];
	logic [31:0]                 data_slots [sbms_pkg::CAPACITY];
	logic [sbms_pkg::SLOT_W-1:0] top_slot   [sbms_pkg::NUM_STACKS];
	logic [sbms_pkg::SLOT_W-1:0] free_top;
	outcome_t                    outcomes_due [$];
	int                          bad_count;

	function new();
		for (int i = 0; i < sbms_pkg::CAPACITY; i++) begin
			link_slots[i] = sbms_pkg::SLOT_W'(i + 1);
			data_slots[i] = '0;
		end
		link_slots[sbms_pkg::CAPACITY-1] = sbms_pkg::NIL_SLOT;
		for (int i = 0; i < sbms_pkg::NUM_STACKS; i++)
			top_slot[i] = sbms_pkg::NIL_SLOT;
		free_top  = '0;
		bad_count = 0;
	endfunction

	function int pending();
		return outcomes_due.size();
	endfunction

	// Apply one accepted transaction to the stores and queue its outcome
	function void note_request(logic op, logic [3:0] num, logic [31:0] word);
		outcome_t                    r;
		int                          sel;
		logic [sbms_pkg::SLOT_W-1:0] slot;
		r.accepted = 1'b0;
		r.word     = (op == sbms_pkg::OP_POP) ? EMPTY_POP_WORD : '0;
		if (num >= 1 && num <= sbms_pkg::NUM_STACKS) begin
			sel = int'(num) - 1;
			if (op == sbms_pkg::OP_PUSH) begin
				slot = free_top;
				if (slot < sbms_pkg::CAPACITY) begin
					free_top         = link_slots[slot];
					data_slots[slot] = word;
					link_slots[slot] = top_slot[sel];
					top_slot[sel]    = slot;
					r.accepted       = 1'b1;
				end
			end else begin
				slot = top_slot[sel];
				if (slot < sbms_pkg::CAPACITY) begin
					top_slot[sel]    = link_slots[slot];
					link_slots[slot] = free_top;
					free_top         = slot;
					r.accepted       = 1'b1;
					r.word           = data_slots[slot];
				end
			end
		end
		outcomes_due.push_back(r);
	endfunction

	function void note_bad(string what, logic [31:0] want, logic [31:0] got);
		bad_count++;
		if (bad_count <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
	endfunction

	// Compare one result from the block against the oldest outcome due
	function void check_result(logic accepted, logic [31:0] word);
		outcome_t r;
		if (outcomes_due.size() == 0) begin
			bad_count++;
			if (bad_count <= 10)
				$display("%0t: result with nothing due: accepted %b, word %h",
					$realtime, accepted, word);
			return;
		end
		r = outcomes_due.pop_front();
		if (accepted !== r.accepted)
			note_bad("accepted", 32'(r.accepted), 32'(accepted));
		if (word !== r.word)
			note_bad("popped_value", r.word, word);
	endfunction
endclass

module tb_shared_buffer_multi_stack_unit;

	localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [4:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	stack_outcome_book book = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_left      = 0;

	shared_buffer_multi_stack_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end

	// Offer one transaction, with random idle cycles ahead of it; called at a falling edge
	task automatic send_op(input logic op, input logic [3:0] num, input logic [31:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = {num, op};
		s_tdata  = word;
		do @(posedge clk); while (!s_tready);
		book.note_request(op, num, word);
		@(negedge clk);
	endtask

	// Stop offering and wait for every outcome due, then let the pipeline settle
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (book.pending() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Random operations; push_pct steers the store toward full or empty
	task automatic random_ops(input int count, input int push_pct);
		logic        op;
		logic [3:0]  num;
		logic [31:0] word;
		int          pick;
		for (int i = 0; i < count; i++) begin
			op   = ($urandom_range(99) < push_pct) ? sbms_pkg::OP_PUSH : sbms_pkg::OP_POP;
			pick = $urandom_range(99);
			if (pick < 8)
				num = $urandom_range(1) ? 4'd0
					: 4'($urandom_range(15, sbms_pkg::NUM_STACKS + 1));
			else
				num = 4'($urandom_range(sbms_pkg::NUM_STACKS, 1));
			pick = $urandom_range(99);
			case (pick % 4)
				0: word = WORD_MAX;
				1: word = WORD_MIN;
				2: word = WORD_ONES;
				default: word = '0;
			endcase
			if (pick >= 12)
				word = $urandom;
			send_op(op, num, word);
		end
	endtask

	// One idling phase: bursts that alternately fill and drain the store
	task automatic run_phase(input int items);
		int push_pct;
		int len;
		push_pct = 85;
		while (items > 0) begin
			len = $urandom_range(15, 60);
			if (len > items)
				len = items;
			random_ops(len, push_pct);
			items    -= len;
			push_pct  = 100 - push_pct;
		end
		drain_results();
	endtask

	// Drive m_tready: a requested long hold-off first, else random stalls
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				m_tready  = 1'b0;
				hold_left--;
			end else begin
				m_tready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Check each result transaction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_result(m_tuser[0], m_tdata);
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty pops, extreme words, out-of-range stack numbers, every stack
		send_op(sbms_pkg::OP_POP,  4'd1,  32'h0000_0000);
		send_op(sbms_pkg::OP_PUSH, 4'd1,  WORD_MAX);
		send_op(sbms_pkg::OP_PUSH, 4'd1,  WORD_MIN);
		send_op(sbms_pkg::OP_PUSH, 4'd8,  WORD_ONES);
		send_op(sbms_pkg::OP_PUSH, 4'd0,  32'h1234_5678);
		send_op(sbms_pkg::OP_POP,  4'd0,  WORD_ONES);
		send_op(sbms_pkg::OP_PUSH, 4'd15, WORD_ONES);
		send_op(sbms_pkg::OP_POP,  4'd15, WORD_ONES);
		send_op(sbms_pkg::OP_PUSH, 4'd9,  32'h0F0F_0F0F);
		send_op(sbms_pkg::OP_POP,  4'd1,  32'h0);
		send_op(sbms_pkg::OP_POP,  4'd1,  32'h0);
		send_op(sbms_pkg::OP_POP,  4'd1,  32'h0);
		send_op(sbms_pkg::OP_POP,  4'd8,  32'h0);
		for (int s = 2; s <= 7; s++)
			send_op(sbms_pkg::OP_PUSH, 4'(s), (s % 2) ? 32'hAAAA_AAAA : 32'h5555_5555);
		for (int s = 2; s <= 7; s++)
			send_op(sbms_pkg::OP_POP, 4'(s), 32'h0);
		drain_results();

		// No idling; hold off the receiver for a long spell, then fill the store past full
		hold_req = 400;
		random_ops(80, 100);
		run_phase(110);

		send_idle_pct  = 80;
		recv_stall_pct = 0;
		run_phase(110);

		send_idle_pct  = 0;
		recv_stall_pct = 80;
		run_phase(110);

		send_idle_pct  = 36;
		recv_stall_pct = 36;
		run_phase(110);

		repeat (10) @(posedge clk);
		if (book.bad_count == 0 && book.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
